// ===== rtl/swrl_pkg.sv =====
// Shared types and constants for the sliding window rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package swrl_pkg;

  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned WC_W = 17;
  localparam logic [15:0] WINDOW_RESET = 16'd60;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_UNCONF = 2'd2;

  typedef struct packed {
    logic action;
    logic [IDX_W-1:0] resource_index;
    logic [CNT_W-1:0] limit;
    logic [TIME_W-1:0] current_time;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic [1:0] status;
    logic [WC_W-1:0] weighted_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_EVAL, S_ROLL_MUL, S_ROLL_DST, S_ROLL_DIV, S_ROLL_SET,
    S_WGT_MUL, S_WGT_DST, S_WGT_DIV, S_DECIDE, S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic mul_en;
    logic mul_roll;
    logic div_start;
    logic roll_set;
    logic decide;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic hit;
    logic roll;
    logic roll_zero;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/swrl_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients below 2^16.
`timescale 1ns / 1ps
`default_nettype none
module swrl_div
  import swrl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [15:0]      quotient
);

  localparam int unsigned STEPS = 16;
  localparam int unsigned CW = $clog2(STEPS + 1);

  logic [15:0]   rem;
  logic [15:0]   dq;
  logic [CW-1:0] cnt;
  logic [16:0]   trial;
  logic          fits;

  assign trial = {rem, dq[15]};
  assign fits = trial >= {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[31:16];
      dq <= dividend[15:0];
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      dq <= {dq[14:0], fits};
    end
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == CW'(1) && !start |=> !busy)
    else $error("divider did not finish after last step");
  a_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with zero step count");
`endif

endmodule
`default_nettype wire

// ===== rtl/swrl_ctrl.sv =====
// Sequencer for the rate limiter: steps one transfer through lookup, rollover and decision.
`timescale 1ns / 1ps
`default_nettype none
module swrl_ctrl
  import swrl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req_valid) state_next = S_LOOKUP;
      S_LOOKUP:   state_next = S_EVAL;
      S_EVAL: begin
        if (stat.is_add || !stat.hit) state_next = S_DECIDE;
        else if (stat.roll && stat.roll_zero) state_next = S_ROLL_SET;
        else if (stat.roll) state_next = S_ROLL_MUL;
        else state_next = S_WGT_MUL;
      end
      S_ROLL_MUL: state_next = S_ROLL_DST;
      S_ROLL_DST: state_next = S_ROLL_DIV;
      S_ROLL_DIV: if (!stat.div_busy) state_next = S_ROLL_SET;
      S_ROLL_SET: state_next = S_WGT_MUL;
      S_WGT_MUL:  state_next = S_WGT_DST;
      S_WGT_DST:  state_next = S_WGT_DIV;
      S_WGT_DIV:  if (!stat.div_busy) state_next = S_DECIDE;
      S_DECIDE:   state_next = S_RESULT;
      S_RESULT:   if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load = req_valid;
      end
      S_LOOKUP:   cmd.lookup = 1'b1;
      S_ROLL_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_roll = 1'b1;
      end
      S_ROLL_DST: cmd.div_start = 1'b1;
      S_ROLL_SET: cmd.roll_set = 1'b1;
      S_WGT_MUL:  cmd.mul_en = 1'b1;
      S_WGT_DST:  cmd.div_start = 1'b1;
      S_DECIDE:   cmd.decide = 1'b1;
      S_RESULT:   cmd.out_load = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/swrl_dp.sv =====
// Datapath: entry table, window arithmetic, shared multiplier and divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module swrl_dp
  import swrl_pkg::*;
#(
  parameter int unsigned RESOURCES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  input  wire req_t        req,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output rsp_t             rsp,
  output logic             rsp_valid,
  input  wire logic        rsp_stall
);

  // Only sixteen indexes are reachable through the request field.
  localparam int unsigned DEPTH = (RESOURCES < 16) ? RESOURCES : 16;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0] window;
  logic [15:0] w;

  logic [DEPTH-1:0]        cfgd;
  logic [CNT_W-1:0]        tbl_lim   [DEPTH];
  logic [CNT_W-1:0]        tbl_cur   [DEPTH];
  logic [CNT_W-1:0]        tbl_prev  [DEPTH];
  logic [TIME_W-1:0]       tbl_start [DEPTH];

  req_t             item;
  logic             inr;
  logic [AW-1:0]    addr;
  logic             cfgd_r;
  logic [CNT_W-1:0] e_lim;
  logic [CNT_W-1:0] e_cur;
  logic [CNT_W-1:0] e_prev;
  logic [TIME_W-1:0] e_start;
  logic [TIME_W-1:0] diff;
  logic [31:0]      prod;
  logic [15:0]      mul_a;
  logic [15:0]      mul_b;
  logic [16:0]      roll_span;
  logic [15:0]      wgt_span;
  logic [15:0]      quot;
  logic             div_busy;
  logic [WC_W-1:0]  weighted;
  logic             under;
  rsp_t             res;
  rsp_t             res_next;

  assign w = (window == '0) ? 16'd1 : window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_write) begin
      window <= cfg_data;
    end
  end

  assign inr = ({28'd0, item.resource_index} < 32'(RESOURCES));
  assign addr = inr ? item.resource_index[AW-1:0] : '0;

  // diff lies in [w, 2w] on the scaled rollover path, so the span fits 16 bits.
  assign roll_span = {w, 1'b0} - diff[16:0];
  assign wgt_span = 16'(w - 16'd1 - diff[15:0]);
  assign mul_a = cmd.mul_roll ? e_cur : e_prev;
  assign mul_b = cmd.mul_roll ? roll_span[15:0] : wgt_span;

  assign weighted = {1'b0, e_cur} + {1'b0, quot};
  assign under = weighted < {1'b0, e_lim};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.lookup) begin
      cfgd_r <= cfgd[addr];
      e_lim <= tbl_lim[addr];
      e_cur <= tbl_cur[addr];
      e_prev <= tbl_prev[addr];
      e_start <= tbl_start[addr];
      diff <= item.current_time - tbl_start[addr];
    end
    if (cmd.mul_en) begin
      prod <= {16'd0, mul_a} * {16'd0, mul_b};
    end
    if (cmd.roll_set) begin
      e_prev <= stat.roll_zero ? '0 : quot;
      e_cur <= '0;
      e_start <= item.current_time;
      diff <= '0;
    end
  end

  // Form the result of the transfer from the looked-up entry.
  always_comb begin
    res_next = '0;
    if (item.action == ACT_ADD) begin
      if (!inr || cfgd_r) begin
        res_next.status = ST_EXISTS;
      end else begin
        res_next.allowed = 1'b1;
      end
    end else if (!stat.hit) begin
      res_next.status = ST_UNCONF;
    end else begin
      res_next.allowed = under;
      res_next.weighted_count = weighted;
    end
  end

  // Settle the result and write back the entry.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res <= res_next;
      if (item.action == ACT_ADD) begin
        if (inr && !cfgd_r) begin
          tbl_lim[addr] <= item.limit;
          tbl_cur[addr] <= '0;
          tbl_prev[addr] <= '0;
          tbl_start[addr] <= '0;
        end
      end else if (stat.hit) begin
        tbl_cur[addr] <= (under && e_cur != COUNT_MAX) ? e_cur + 1'b1 : e_cur;
        tbl_prev[addr] <= e_prev;
        tbl_start[addr] <= e_start;
      end
    end
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfgd <= '0;
    end else if (cmd.decide && item.action == ACT_ADD && inr && !cfgd_r) begin
      cfgd[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  swrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (w),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    stat.is_add = (item.action == ACT_ADD);
    stat.hit = inr && cfgd_r;
    stat.roll = diff >= {16'd0, w};
    stat.roll_zero = diff > {15'd0, w, 1'b0};
    stat.div_busy = div_busy;
    stat.out_free = !rsp_valid || !rsp_stall;
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_rate_limiter.sv =====
// Top level of the per-resource sliding window rate limiter.
// An add or an unconfigured request goes from lookup to decision; an open window adds a
//   weighting division, a lapsed window a rollover reset, a scaled rollover a second division.
// One transfer at a time, with up to two 16-step serial divisions each; the next input
//   enters the cycle after the result loads its output register.
// Reset (rst, synchronous): clears configured flags, sets the window size to 60, empties output.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int unsigned RESOURCES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp
);

  // Command and status bundles between sequencer and datapath.
  cmd_t  cmd;
  stat_t stat;

  swrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  swrl_dp #(
    .RESOURCES (RESOURCES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

`ifndef ASSERT_OFF
  // An accepted transfer occupies the sequencer on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input not held off after a transfer");
  // Only an ok status may carry a grant.
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.allowed |-> rsp.status == ST_OK)
    else $error("grant with error status");
  // Error results report a zero count and no grant.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> !rsp.allowed && rsp.weighted_count == '0)
    else $error("error result with nonzero count");
`endif

endmodule
`default_nettype wire
